// ===== design/bbpa_pkg.sv =====
// Shared types and constants for the bitmap buffer pool allocator.
// Holds the controller state encoding, status codes and the result word.
// No dependencies.
package bbpa_pkg;

	// Fixed field widths of the request, result and configuration ports.
	localparam int SLOT_W  = 8;
	localparam int COUNT_W = 9;
	localparam int CFG_W   = 9;

	// The slot index is split into word and bit by a reciprocal multiply.
	localparam int RECIP_SHIFT = 16;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam int PROD_W      = SLOT_W + RECIP_W;

	// Request opcodes.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_RANGE  = 2'd2,
		STAT_DOUBLE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FDIV,
		ST_FADDR,
		ST_FCHK
	} state_t;

	// One result word handed from the controller to the output register.
	typedef struct packed {
		status_t             status;
		logic [SLOT_W-1:0]   granted_slot;
		logic [COUNT_W-1:0]  in_use_count;
		logic [COUNT_W-1:0]  peak_in_use;
	} res_t;

endpackage

// ===== design/bbpa_map_ram.sv =====
// Free bitmap storage: one write port, one read port, registered read data.
// Generic synchronous memory with no dependencies.
module bbpa_map_ram #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 32,
	parameter int AW    = 3
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port with registered read data.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/bbpa_ctrl.sv =====
// Allocator controller: clearing pass, pipelined word scan, free read-modify-write.
// Depends on bbpa_pkg; drives the bitmap memory bbpa_map_ram through its ports.
module bbpa_ctrl
	import bbpa_pkg::*;
#(
	parameter int MAX_SLOTS = 256,
	parameter int WORD_BITS = 32,
	parameter int NUM_WORDS = MAX_SLOTS / WORD_BITS,
	parameter int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1,
	parameter int CW        = ($clog2(MAX_SLOTS + 1) > COUNT_W) ?
	                          $clog2(MAX_SLOTS + 1) : COUNT_W
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [CW-1:0]        limit,
	input  logic                 start,
	input  logic                 op,
	input  logic [SLOT_W-1:0]    slot_index,
	output logic                 busy,
	output logic                 res_valid,
	output res_t                 res,
	output logic                 ram_we,
	output logic [AW-1:0]        ram_waddr,
	output logic [WORD_BITS-1:0] ram_wdata,
	output logic                 ram_re,
	output logic [AW-1:0]        ram_raddr,
	input  logic [WORD_BITS-1:0] ram_rdata
);

	localparam int WCW   = $clog2(NUM_WORDS + 1);
	localparam int BW    = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
	localparam int RECIP = (1 << RECIP_SHIFT) / WORD_BITS + 1;

	state_t state_q, state_d;

	logic [WCW-1:0]       clr_q;
	logic [WCW-1:0]       rw_q;
	logic [CW-1:0]        rbase_q;
	logic                 chk_s1;
	logic [AW-1:0]        cw_s1;
	logic [CW-1:0]        cbase_s1;
	logic [SLOT_W-1:0]    fidx_q;
	logic [SLOT_W:0]      fq_q;
	logic [BW-1:0]        fb_q;
	logic [CW-1:0]        used_q;
	logic [CW-1:0]        peak_q;

	// Control events from the state machine to the datapath registers.
	logic clr_step, scan_init, scan_issue, cnt_inc, cnt_dec, fidx_load, fq_load, fb_load;

	logic [WORD_BITS-1:0] lim_mask;
	logic [WORD_BITS-1:0] avail;
	logic                 avail_any;
	logic [BW-1:0]        fbit;
	logic                 more;
	logic [CW-1:0]        used_inc;
	logic [CW-1:0]        used_dec;
	logic [CW-1:0]        peak_new;
	logic [PROD_W-1:0]    prod;
	logic [SLOT_W:0]      fb_wide;

	// Bits of the checked word that lie below the slot limit, and the lowest free one.
	always_comb begin
		lim_mask = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			lim_mask[i] = (32'(cbase_s1) + 32'(i)) < 32'(limit);
		end
		avail     = ram_rdata & lim_mask;
		avail_any = |avail;
		fbit      = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (avail[i]) begin
				fbit = BW'(i);
			end
		end
	end

	// Another word remains to be read while it exists and starts below the limit.
	assign more = (32'(rw_q) < 32'(NUM_WORDS)) && (rbase_q < limit);

	assign used_inc = used_q + CW'(1);
	assign used_dec = (used_q != '0) ? used_q - CW'(1) : used_q;
	assign peak_new = (used_inc > peak_q) ? used_inc : peak_q;

	// Word and bit of a freed slot: reciprocal multiply, then remainder.
	assign prod    = PROD_W'(fidx_q) * PROD_W'(RECIP);
	assign fb_wide = (SLOT_W + 1)'(fidx_q) - (SLOT_W + 1)'(32'(fq_q) * 32'(WORD_BITS));

	assign busy = (state_q != ST_IDLE);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, memory controls and result.
	always_comb begin
		state_d    = state_q;
		clr_step   = 1'b0;
		scan_init  = 1'b0;
		scan_issue = 1'b0;
		cnt_inc    = 1'b0;
		cnt_dec    = 1'b0;
		fidx_load  = 1'b0;
		fq_load    = 1'b0;
		fb_load    = 1'b0;
		ram_we     = 1'b0;
		ram_waddr  = cw_s1;
		ram_wdata  = ram_rdata;
		ram_re     = 1'b0;
		ram_raddr  = rw_q[AW-1:0];
		res_valid  = 1'b0;
		res.status       = STAT_OK;
		res.granted_slot = '0;
		res.in_use_count = COUNT_W'(used_q);
		res.peak_in_use  = COUNT_W'(peak_q);

		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q[AW-1:0];
				ram_wdata = '1;
				clr_step  = 1'b1;
				if (32'(clr_q) >= 32'(NUM_WORDS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					if (op == OP_ALLOC) begin
						scan_init = 1'b1;
						state_d   = ST_SCAN;
					end else begin
						fidx_load = 1'b1;
						state_d   = ST_FDIV;
					end
				end
			end
			ST_SCAN: begin
				if (chk_s1 && avail_any) begin
					// Grant the lowest free bit of the checked word.
					ram_we    = 1'b1;
					ram_waddr = cw_s1;
					ram_wdata = ram_rdata & ~(WORD_BITS'(1) << fbit);
					cnt_inc   = 1'b1;
					res_valid = 1'b1;
					res.granted_slot = SLOT_W'(32'(cbase_s1) + 32'(fbit));
					res.in_use_count = COUNT_W'(used_inc);
					res.peak_in_use  = COUNT_W'(peak_new);
					state_d   = ST_IDLE;
				end else if (more) begin
					ram_re     = 1'b1;
					ram_raddr  = rw_q[AW-1:0];
					scan_issue = 1'b1;
				end else begin
					res_valid  = 1'b1;
					res.status = STAT_FULL;
					state_d    = ST_IDLE;
				end
			end
			ST_FDIV: begin
				if (32'(fidx_q) >= 32'(limit)) begin
					res_valid  = 1'b1;
					res.status = STAT_RANGE;
					state_d    = ST_IDLE;
				end else begin
					fq_load = 1'b1;
					state_d = ST_FADDR;
				end
			end
			ST_FADDR: begin
				if (32'(fq_q) >= 32'(NUM_WORDS)) begin
					res_valid  = 1'b1;
					res.status = STAT_DOUBLE;
					state_d    = ST_IDLE;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = fq_q[AW-1:0];
					fb_load   = 1'b1;
					state_d   = ST_FCHK;
				end
			end
			ST_FCHK: begin
				res_valid = 1'b1;
				state_d   = ST_IDLE;
				if (ram_rdata[fb_q]) begin
					res.status = STAT_DOUBLE;
				end else begin
					ram_we    = 1'b1;
					ram_waddr = fq_q[AW-1:0];
					ram_wdata = ram_rdata | (WORD_BITS'(1) << fb_q);
					cnt_dec   = 1'b1;
					res.in_use_count = COUNT_W'(used_dec);
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers: clear counter, check stage valid, counts.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			chk_s1 <= 1'b0;
			used_q <= '0;
			peak_q <= '0;
		end else begin
			if (clr_step) begin
				clr_q <= clr_q + WCW'(1);
			end
			chk_s1 <= scan_issue;
			if (cnt_inc) begin
				used_q <= used_inc;
				peak_q <= peak_new;
			end else if (cnt_dec) begin
				used_q <= used_dec;
			end
		end
	end

	// Scan and free datapath registers.
	always_ff @(posedge clk) begin
		if (scan_init) begin
			rw_q    <= '0;
			rbase_q <= '0;
		end else if (scan_issue) begin
			rw_q    <= rw_q + WCW'(1);
			rbase_q <= rbase_q + CW'(WORD_BITS);
		end
		if (scan_issue) begin
			cw_s1    <= rw_q[AW-1:0];
			cbase_s1 <= rbase_q;
		end
		if (fidx_load) begin
			fidx_q <= slot_index;
		end
		if (fq_load) begin
			fq_q <= prod[RECIP_SHIFT +: (SLOT_W + 1)];
		end
		if (fb_load) begin
			fb_q <= fb_wide[BW-1:0];
		end
	end

endmodule

// ===== design/bitmap_buffer_pool_allocator.sv =====
// Top level of the bitmap buffer pool allocator: slot limit register and result register.
// Depends on bbpa_pkg, bbpa_ctrl and bbpa_map_ram.
//
// A request is taken when start is high and busy is low; its result word is shown for
// exactly one cycle with done high, and the receiver cannot stall it. After reset the
// block runs a clearing pass over every bitmap word with busy high. An allocate scans
// bitmap words in order for a free slot below the limit; a free reads and may rewrite one
// word, or gives a range status for a slot at or above the limit. Busy stays high until
// the result, so a new request waits for the last one. The scan is paced by the bitmap
// memory's single read port, which delivers one word per cycle to the scan. The slot
// limit is written through cfg_valid, and cfg_ready is always high; a request in progress
// sees a new limit at once, so the limit should only be changed while busy is low.
module bitmap_buffer_pool_allocator
	import bbpa_pkg::*;
#(
	parameter int MAX_SLOTS = 256,
	parameter int WORD_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               start,
	output logic               busy,
	input  logic               op,
	input  logic [SLOT_W-1:0]  slot_index,
	output logic               done,
	output logic [1:0]         status,
	output logic [SLOT_W-1:0]  granted_slot,
	output logic [COUNT_W-1:0] in_use_count,
	output logic [COUNT_W-1:0] peak_in_use
);

	localparam int NUM_WORDS = MAX_SLOTS / WORD_BITS;
	localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int CW        = ($clog2(MAX_SLOTS + 1) > COUNT_W) ?
	                           $clog2(MAX_SLOTS + 1) : COUNT_W;

	logic [CFG_W-1:0]     slots_q;
	logic [CW-1:0]        limit;
	logic                 res_valid;
	res_t                 res;
	res_t                 res_q;
	logic                 done_q;
	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic                 ram_re;
	logic [AW-1:0]        ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	assign cfg_ready = 1'b1;

	// Slot limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= CFG_W'(256);
		end else if (cfg_valid && cfg_ready) begin
			slots_q <= cfg_data;
		end
	end

	// A limit above the pool size acts as the pool size.
	assign limit = (CW'(slots_q) > CW'(MAX_SLOTS)) ? CW'(MAX_SLOTS) : CW'(slots_q);

	bbpa_ctrl #(
		.MAX_SLOTS (MAX_SLOTS),
		.WORD_BITS (WORD_BITS),
		.NUM_WORDS (NUM_WORDS),
		.AW        (AW),
		.CW        (CW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.limit      (limit),
		.start      (start),
		.op         (op),
		.slot_index (slot_index),
		.busy       (busy),
		.res_valid  (res_valid),
		.res        (res),
		.ram_we     (ram_we),
		.ram_waddr  (ram_waddr),
		.ram_wdata  (ram_wdata),
		.ram_re     (ram_re),
		.ram_raddr  (ram_raddr),
		.ram_rdata  (ram_rdata)
	);

	bbpa_map_ram #(
		.DEPTH (NUM_WORDS),
		.WIDTH (WORD_BITS),
		.AW    (AW)
	) u_map_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res_valid;
		end
	end

	// Result word register.
	always_ff @(posedge clk) begin
		if (res_valid) begin
			res_q <= res;
		end
	end

	assign done         = done_q;
	assign status       = res_q.status;
	assign granted_slot = res_q.granted_slot;
	assign in_use_count = res_q.in_use_count;
	assign peak_in_use  = res_q.peak_in_use;

endmodule

// ===== tb/tb.sv =====
// Testbench for the bitmap buffer pool allocator: directed and random allocate and free words,
// each result checked against a slot-bitmap predictor kept in a small scoreboard class.
// Depends on bbpa_pkg and bitmap_buffer_pool_allocator.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bbpa_pkg::*;

	localparam int MAX_SLOTS  = 256;
	localparam int WORD_BITS  = 32;
	localparam int NUM_WORDS  = MAX_SLOTS / WORD_BITS;
	localparam int CLK_HALF   = 5;
	localparam int IDLE_LIMIT = 2000;
	localparam int SETTLE     = 12;

	// Predicts the result word of each request from its own copy of the free bitmap,
	// the counters and the slot limit, queues it, and checks result words against that queue.
	class pool_scoreboard;
		bit [WORD_BITS-1:0] free_words [NUM_WORDS];
		bit [COUNT_W-1:0]   used_slots;
		bit [COUNT_W-1:0]   peak_slots;
		bit [CFG_W-1:0]     slot_limit;
		res_t               pending_results [$];
		int                 errors;

		function new();
			foreach (free_words[w]) begin
				free_words[w] = '1;
			end
			used_slots = '0;
			peak_slots = '0;
			slot_limit = 9'd256;
			errors     = 0;
		endfunction

		function void write_limit(bit [CFG_W-1:0] value);
			slot_limit = value;
		endfunction

		// A limit above the pool size acts as the pool size.
		function int unsigned grant_bound();
			return (slot_limit > MAX_SLOTS) ? MAX_SLOTS : slot_limit;
		endfunction

		function bit slot_taken(int unsigned slot);
			return !free_words[slot / WORD_BITS][slot % WORD_BITS];
		endfunction

		function void note_request(logic req_op, logic [SLOT_W-1:0] idx);
			res_t        r;
			int unsigned bound;
			bit          found;
			bound          = grant_bound();
			r.status       = STAT_OK;
			r.granted_slot = '0;
			if (req_op == OP_ALLOC) begin
				// Scanning words in order and bits from the bottom gives the lowest free slot.
				found = 1'b0;
				for (int s = 0; s < bound && !found; s++) begin
					if (free_words[s / WORD_BITS][s % WORD_BITS]) begin
						free_words[s / WORD_BITS][s % WORD_BITS] = 1'b0;
						r.granted_slot = SLOT_W'(s);
						used_slots++;
						if (used_slots > peak_slots)
							peak_slots = used_slots;
						found = 1'b1;
					end
				end
				if (!found)
					r.status = STAT_FULL;
			end else if (idx >= bound) begin
				r.status = STAT_RANGE;
			end else if (!slot_taken(idx)) begin
				r.status = STAT_DOUBLE;
			end else begin
				free_words[idx / WORD_BITS][idx % WORD_BITS] = 1'b1;
				if (used_slots != 0)
					used_slots--;
			end
			r.in_use_count = used_slots;
			r.peak_in_use  = peak_slots;
			pending_results.push_back(r);
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (pending_results.size() == 0) begin
				$error("result word with no request outstanding: status %0d slot %0d",
					got.status, got.granted_slot);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.granted_slot !== want.granted_slot) begin
				$error("granted_slot: expected %0d, got %0d", want.granted_slot, got.granted_slot);
				errors++;
			end
			if (got.in_use_count !== want.in_use_count) begin
				$error("in_use_count: expected %0d, got %0d", want.in_use_count, got.in_use_count);
				errors++;
			end
			if (got.peak_in_use !== want.peak_in_use) begin
				$error("peak_in_use: expected %0d, got %0d", want.peak_in_use, got.peak_in_use);
				errors++;
			end
		endfunction
	endclass

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               cfg_valid  = 1'b0;
	logic               cfg_ready;
	logic [CFG_W-1:0]   cfg_data   = '0;
	logic               start      = 1'b0;
	logic               busy;
	logic               op         = OP_ALLOC;
	logic [SLOT_W-1:0]  slot_index = '0;
	logic               done;
	logic [1:0]         status;
	logic [SLOT_W-1:0]  granted_slot;
	logic [COUNT_W-1:0] in_use_count;
	logic [COUNT_W-1:0] peak_in_use;

	pool_scoreboard sb = new();
	int burst_left  = 0;
	int words_sent  = 0;
	int idle_cycles = 0;

	bitmap_buffer_pool_allocator #(
		.MAX_SLOTS(MAX_SLOTS),
		.WORD_BITS(WORD_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.op(op),
		.slot_index(slot_index),
		.done(done),
		.status(status),
		.granted_slot(granted_slot),
		.in_use_count(in_use_count),
		.peak_in_use(peak_in_use)
	);

	always #CLK_HALF clk = ~clk;

	// Every result word is checked at the edge that ends its strobe cycle.
	always @(posedge clk) begin
		res_t got;
		if (arst_n && done) begin
			got.status       = status_t'(status);
			got.granted_slot = granted_slot;
			got.in_use_count = in_use_count;
			got.peak_in_use  = peak_in_use;
			sb.check_result(got);
		end
	end

	// Watchdog: the run ends if no word moves on any port for too long.
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("bitmap_buffer_pool_allocator test failed");
			$finish;
		end
	end

	// Sends one request word; requests come in bursts, most of them separated by random gaps.
	task automatic send_request(input logic req_op, input logic [SLOT_W-1:0] idx);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			if (gap != 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		start      <= 1'b1;
		op         <= req_op;
		slot_index <= idx;
		do @(posedge clk); while (busy);
		sb.note_request(req_op, idx);
		burst_left--;
		words_sent++;
	endtask

	// Holds off new requests until every outstanding result word has come back.
	task automatic drain_results();
		if (start)
			start <= 1'b0;
		burst_left = 0;
		while (sb.pending_results.size() != 0)
			@(posedge clk);
	endtask

	// The slot limit is only changed with the block idle.
	task automatic set_slot_limit(input logic [CFG_W-1:0] value);
		drain_results();
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.write_limit(value);
		cfg_valid <= 1'b0;
	endtask

	// Picks a slot that is currently allocated, starting from a random point, or a random slot when none is.
	function automatic logic [SLOT_W-1:0] pick_taken_slot();
		int unsigned first;
		first = $urandom_range(0, MAX_SLOTS - 1);
		for (int k = 0; k < MAX_SLOTS; k++) begin
			if (sb.slot_taken((first + k) % MAX_SLOTS))
				return SLOT_W'((first + k) % MAX_SLOTS);
		end
		return SLOT_W'($urandom_range(0, MAX_SLOTS - 1));
	endfunction

	// Allocates at alloc_pct percent; frees hit mostly allocated slots, some arbitrary ones as noise.
	task automatic run_phase(input int n_words, input int alloc_pct);
		for (int i = 0; i < n_words; i++) begin
			if ($urandom_range(0, 39) == 0)
				drain_results();
			if ($urandom_range(0, 99) < alloc_pct)
				send_request(OP_ALLOC, SLOT_W'($urandom));
			else if ($urandom_range(0, 3) != 0)
				send_request(OP_FREE, pick_taken_slot());
			else
				send_request(OP_FREE, SLOT_W'($urandom));
		end
	endtask

	initial begin
		logic [CFG_W-1:0] next_limit;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Reset limit: grants from the bottom, accepted frees, double frees of a freed slot and of the top slot.
		send_request(OP_ALLOC, 8'h00);
		send_request(OP_ALLOC, 8'hFF);
		send_request(OP_ALLOC, 8'h00);
		send_request(OP_FREE, 8'd1);
		send_request(OP_FREE, 8'd1);
		send_request(OP_ALLOC, 8'h55);
		send_request(OP_FREE, 8'd255);
		send_request(OP_FREE, 8'd0);

		// Zero limit: pool full, and frees out of range even for a slot still allocated.
		set_slot_limit(9'd0);
		send_request(OP_ALLOC, 8'h00);
		send_request(OP_FREE, 8'd0);
		send_request(OP_FREE, 8'd2);
		send_request(OP_FREE, 8'd255);

		// Limit above the pool acts as the whole pool; the stranded slot can be freed again.
		set_slot_limit(9'd511);
		send_request(OP_FREE, 8'd2);
		send_request(OP_ALLOC, 8'h00);
		send_request(OP_ALLOC, 8'hAA);

		// One-slot pool.
		set_slot_limit(9'd1);
		send_request(OP_ALLOC, 8'h00);
		send_request(OP_FREE, 8'd0);
		send_request(OP_ALLOC, 8'h00);

		// Fill the whole pool past full, then run mostly frees, then limits around the pool size.
		set_slot_limit(9'd511);
		run_phase(300, 90);
		set_slot_limit(9'd256);
		run_phase(150, 20);
		set_slot_limit(9'd255);
		run_phase(60, 60);
		set_slot_limit(9'd257);
		run_phase(60, 50);

		// Random limits, small ones most often so that the pool runs full.
		while (words_sent < 960) begin
			case ($urandom_range(0, 3))
				0: next_limit = CFG_W'($urandom_range(0, 511));
				1: next_limit = CFG_W'($urandom_range(0, 8));
				default: next_limit = CFG_W'($urandom_range(1, 64));
			endcase
			set_slot_limit(next_limit);
			run_phase($urandom_range(30, 90), $urandom_range(25, 85));
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("bitmap_buffer_pool_allocator test passed");
		else
			$display("bitmap_buffer_pool_allocator test failed");
		$finish;
	end

endmodule
